### hdl/fbfl_pkg.sv
`timescale 1ns / 1ps

package fbfl_pkg;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int IDX_W  = 8;
  localparam int CNT_W  = 9;
  localparam int BB_W   = 13;
  localparam int OFF_W  = 20;
  localparam int ST_W   = 2;
  localparam int CFG_AW = 1;
  localparam int CFG_DW = 13;

  // Default geometry
  localparam int MAX_BLOCKS_DEF = 256;
  localparam int WORD_BYTES_DEF = 8;

  // Reset values of the configuration registers
  localparam logic [CNT_W-1:0] BLOCKS_IN_USE_RST = CNT_W'(256);
  localparam logic [BB_W-1:0]  BLOCK_BYTES_RST   = BB_W'(8);

  // Block size rounding: size up to 8198 fits in 14 bits, quotient in 12
  localparam int EFF_W    = 14;
  localparam int Q_W      = 12;
  localparam int RECIP_SH = 17;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_INIT_FAIL = 2'd2
  } status_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_BLOCKS_IN_USE = 1'b0,
    CFG_BLOCK_BYTES   = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_ALLOC,
    S_INIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic    cfg_we;
    logic    load_item;
    logic    alloc_rd;
    logic    alloc_done;
    logic    free_done;
    logic    init_clear;
    logic    init_step;
    logic    init_done;
    logic    resp_only;
    status_t resp_status;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic head_null;
    logic cnt_zero;
    logic init_last;
    logic out_free;
    logic settled;
  } dp_stat_t;

endpackage

### hdl/fbfl_ram.sv
`timescale 1ns / 1ps

module fbfl_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/fbfl_dp.sv
`timescale 1ns / 1ps

module fbfl_dp #(
  parameter int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF,
  parameter int WORD_BYTES = fbfl_pkg::WORD_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fbfl_pkg::dp_cmd_t            cmd_i,
  output fbfl_pkg::dp_stat_t           stat_o,
  input  logic [fbfl_pkg::CMD_W-1:0]   in_cmd,
  input  logic [fbfl_pkg::IDX_W-1:0]   in_free_index,
  input  logic                         in_free_is_null,
  input  logic [fbfl_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [fbfl_pkg::CFG_DW-1:0]  cfg_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [fbfl_pkg::ST_W-1:0]    out_status,
  output logic [fbfl_pkg::IDX_W-1:0]   out_block_index,
  output logic [fbfl_pkg::OFF_W-1:0]   out_block_offset,
  output logic [fbfl_pkg::CNT_W-1:0]   out_free_count
);

  import fbfl_pkg::*;

  localparam int LW    = $clog2(MAX_BLOCKS + 1);
  localparam int AW    = $clog2(MAX_BLOCKS);
  localparam int RECIP = ((1 << RECIP_SH) + WORD_BYTES - 1) / WORD_BYTES;
  localparam logic [LW-1:0] NULL_IDX = LW'(MAX_BLOCKS);

  // Configuration
  logic [CNT_W-1:0] blocks_in_use_r;
  logic [BB_W-1:0]  block_bytes_r;
  logic [1:0]       pend_r, pend_nxt;

  // Effective block size pipeline
  logic [BB_W-1:0]  sz_c;
  logic [EFF_W-1:0] rnd_c;
  logic [31:0]      recip_prod_c;
  logic [Q_W-1:0]   q_r;
  logic [EFF_W-1:0] eff_r;

  // Current word
  cmd_t             cmd_r;
  logic [IDX_W-1:0] fidx_r;
  logic             fnull_r;

  // List state
  logic [LW-1:0]    head_r, head_nxt;
  logic [LW-1:0]    total_r, total_nxt;
  logic [LW-1:0]    ptr_r, ptr_nxt;
  logic [LW-1:0]    ptr_inc;
  logic [LW-1:0]    count_c;
  logic             init_last;
  logic             free_ok;
  logic [OFF_W-1:0] prod_r;

  // Link store
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [LW-1:0]    wr_data;
  logic [LW-1:0]    rd_data;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  logic             out_load;
  logic             out_free;
  status_t          status_r;
  logic [IDX_W-1:0] idx_r;
  logic [OFF_W-1:0] off_r;
  logic [CNT_W-1:0] fcnt_r;

  // Config registers and settle counter for the size pipeline
  always_comb begin
    pend_nxt = pend_r;
    if (cmd_i.cfg_we) begin
      pend_nxt = 2'd2;
    end else if (pend_r != 2'd0) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocks_in_use_r <= BLOCKS_IN_USE_RST;
      block_bytes_r   <= BLOCK_BYTES_RST;
      pend_r          <= 2'd2;
    end else begin
      pend_r <= pend_nxt;
      if (cmd_i.cfg_we && cfg_addr == CFG_BLOCKS_IN_USE) begin
        blocks_in_use_r <= cfg_data[CNT_W-1:0];
      end
      if (cmd_i.cfg_we && cfg_addr == CFG_BLOCK_BYTES) begin
        block_bytes_r <= cfg_data[BB_W-1:0];
      end
    end
  end

  // Size = max(bytes, word) rounded up to a word, via reciprocal multiply
  assign sz_c  = (block_bytes_r < BB_W'(WORD_BYTES)) ? BB_W'(WORD_BYTES) : block_bytes_r;
  assign rnd_c = EFF_W'(sz_c) + EFF_W'(WORD_BYTES - 1);
  assign recip_prod_c = 32'(rnd_c) * 32'(RECIP);

  always_ff @(posedge clk) begin
    q_r   <= Q_W'(recip_prod_c >> RECIP_SH);
    eff_r <= EFF_W'(32'(q_r) * 32'(WORD_BYTES));
  end

  // Capture the accepted word
  always_ff @(posedge clk) begin
    if (cmd_i.load_item) begin
      cmd_r   <= cmd_t'(in_cmd);
      fidx_r  <= in_free_index;
      fnull_r <= in_free_is_null;
    end
  end

  // Clamped init count and walk pointer
  always_comb begin
    if (int'(blocks_in_use_r) > MAX_BLOCKS) begin
      count_c = NULL_IDX;
    end else begin
      count_c = LW'(blocks_in_use_r);
    end
  end

  assign ptr_inc   = ptr_r + LW'(1);
  assign init_last = (ptr_inc == count_c);
  assign free_ok   = !fnull_r && (int'(fidx_r) < MAX_BLOCKS);

  // Link store port muxing
  assign wr_en   = cmd_i.init_step | (cmd_i.free_done & free_ok);
  assign wr_addr = cmd_i.init_step ? AW'(ptr_r) : AW'(fidx_r);
  assign wr_data = cmd_i.init_step ? (init_last ? NULL_IDX : ptr_inc) : head_r;

  fbfl_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_BLOCKS)
  ) u_link (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd_i.alloc_rd),
    .rd_addr (AW'(head_r)),
    .rd_data (rd_data)
  );

  // Head, free count and walk pointer updates
  always_comb begin
    head_nxt  = head_r;
    total_nxt = total_r;
    ptr_nxt   = ptr_r;
    if (cmd_i.alloc_done) begin
      head_nxt = rd_data;
      if (total_r != '0) begin
        total_nxt = total_r - LW'(1);
      end
    end
    if (cmd_i.free_done && free_ok) begin
      head_nxt = LW'(fidx_r);
      if (total_r < NULL_IDX) begin
        total_nxt = total_r + LW'(1);
      end
    end
    if (cmd_i.init_done) begin
      head_nxt  = '0;
      total_nxt = count_c;
    end
    if (cmd_i.init_clear) begin
      ptr_nxt = '0;
    end else if (cmd_i.init_step && !init_last) begin
      ptr_nxt = ptr_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= NULL_IDX;
      total_r <= '0;
      ptr_r   <= '0;
    end else begin
      head_r  <= head_nxt;
      total_r <= total_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  // Offset product, taken while the link read is in flight
  always_ff @(posedge clk) begin
    if (cmd_i.alloc_rd) begin
      prod_r <= OFF_W'(head_r) * OFF_W'(eff_r);
    end
  end

  // Output register
  assign out_load = cmd_i.alloc_done | cmd_i.free_done | cmd_i.init_done | cmd_i.resp_only;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status_r <= cmd_i.resp_only ? cmd_i.resp_status : ST_OK;
      idx_r    <= cmd_i.alloc_done ? IDX_W'(head_r) : '0;
      off_r    <= cmd_i.alloc_done ? (OFF_W'(WORD_BYTES) + prod_r) : '0;
      fcnt_r   <= CNT_W'(total_nxt);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_block_index  = idx_r;
  assign out_block_offset = off_r;
  assign out_free_count   = fcnt_r;

  // Status to the controller
  assign stat_o.cmd       = cmd_r;
  assign stat_o.head_null = (head_r >= NULL_IDX);
  assign stat_o.cnt_zero  = (count_c == '0);
  assign stat_o.init_last = init_last;
  assign stat_o.out_free  = out_free;
  assign stat_o.settled   = (pend_r == 2'd0);

endmodule

### hdl/fbfl_ctrl.sv
`timescale 1ns / 1ps

module fbfl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  fbfl_pkg::dp_stat_t stat_i,
  output fbfl_pkg::dp_cmd_t  cmd_o
);

  import fbfl_pkg::*;

  state_t state_r, state_nxt;
  logic   in_fire;

  // Config has priority so the two channels never fire together
  assign cfg_ready = (state_r == S_IDLE);
  assign in_ready  = (state_r == S_IDLE) && stat_i.settled && !cfg_valid;
  assign in_fire   = in_valid && in_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat_i.cmd)
          CMD_INIT: begin
            if (!stat_i.cnt_zero) begin
              state_nxt = S_INIT;
            end else if (stat_i.out_free) begin
              state_nxt = S_IDLE;
            end
          end
          CMD_ALLOC: begin
            if (!stat_i.head_null) begin
              state_nxt = S_ALLOC;
            end else if (stat_i.out_free) begin
              state_nxt = S_IDLE;
            end
          end
          CMD_FREE, CMD_NOP: begin
            if (stat_i.out_free) begin
              state_nxt = S_IDLE;
            end
          end
        endcase
      end
      S_ALLOC: begin
        if (stat_i.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_INIT: begin
        if (stat_i.init_last && stat_i.out_free) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath commands; every commit waits for a free output register
  always_comb begin
    cmd_o.cfg_we      = cfg_valid && cfg_ready;
    cmd_o.load_item   = in_fire;
    cmd_o.alloc_rd    = 1'b0;
    cmd_o.alloc_done  = 1'b0;
    cmd_o.free_done   = 1'b0;
    cmd_o.init_clear  = 1'b0;
    cmd_o.init_step   = 1'b0;
    cmd_o.init_done   = 1'b0;
    cmd_o.resp_only   = 1'b0;
    cmd_o.resp_status = ST_OK;
    unique case (state_r)
      S_IDLE: begin
      end
      S_DECODE: begin
        unique case (stat_i.cmd)
          CMD_INIT: begin
            if (!stat_i.cnt_zero) begin
              cmd_o.init_clear = 1'b1;
            end else begin
              cmd_o.resp_only   = stat_i.out_free;
              cmd_o.resp_status = ST_INIT_FAIL;
            end
          end
          CMD_ALLOC: begin
            if (!stat_i.head_null) begin
              cmd_o.alloc_rd = 1'b1;
            end else begin
              cmd_o.resp_only   = stat_i.out_free;
              cmd_o.resp_status = ST_EMPTY;
            end
          end
          CMD_FREE: begin
            cmd_o.free_done = stat_i.out_free;
          end
          CMD_NOP: begin
            cmd_o.resp_only = stat_i.out_free;
          end
        endcase
      end
      S_ALLOC: begin
        cmd_o.alloc_done = stat_i.out_free;
      end
      S_INIT: begin
        cmd_o.init_step = 1'b1;
        cmd_o.init_done = stat_i.init_last && stat_i.out_free;
      end
    endcase
  end

endmodule

### hdl/fixed_block_free_list_allocator_core.sv
`timescale 1ns / 1ps

// Fixed-size block allocator over a linked free list.
// Input channel (in_valid/in_ready): one command word, in_cmd init, allocate,
// free or no-op, with in_free_index and in_free_is_null for a free.
// Output channel (out_valid/out_ready): exactly one result word per command:
// status, allocated index and byte offset, and the free count afterwards.
// Config channel (cfg_valid/cfg_ready): cfg_addr 0 sets blocks_in_use,
// cfg_addr 1 sets block_bytes; written between commands only.
// Steps per command, accept to result: free and no-op commit in decode;
// allocate does a registered read of the link memory, then the head update;
// a failed allocate or failed init answers from decode; init writes the link
// memory once per block. The block takes one command at a time; in_ready
// returns in the cycle after the result is loaded, so the result register
// and a new command overlap. A stalled receiver holds the result register;
// the next command's commit waits until it drains. After reset and after
// each config write, in_ready stays low while the block size pipeline settles.
// Reset empties the list (head null, count zero); the link memory is not
// cleared and is only meaningful after init or free.

module fixed_block_free_list_allocator_core #(
  parameter int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF,
  parameter int WORD_BYTES = fbfl_pkg::WORD_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [fbfl_pkg::CMD_W-1:0]  in_cmd,
  input  logic [fbfl_pkg::IDX_W-1:0]  in_free_index,
  input  logic                        in_free_is_null,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fbfl_pkg::ST_W-1:0]   out_status,
  output logic [fbfl_pkg::IDX_W-1:0]  out_block_index,
  output logic [fbfl_pkg::OFF_W-1:0]  out_block_offset,
  output logic [fbfl_pkg::CNT_W-1:0]  out_free_count,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [fbfl_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [fbfl_pkg::CFG_DW-1:0] cfg_data
);

  import fbfl_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  fbfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat_i    (dp_stat),
    .cmd_o     (dp_cmd)
  );

  fbfl_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .WORD_BYTES (WORD_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_i            (dp_cmd),
    .stat_o           (dp_stat),
    .in_cmd           (in_cmd),
    .in_free_index    (in_free_index),
    .in_free_is_null  (in_free_is_null),
    .cfg_addr         (cfg_addr),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_block_index  (out_block_index),
    .out_block_offset (out_block_offset),
    .out_free_count   (out_free_count)
  );

  // A command word and a config write never land on the same edge
  assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && in_ready && cfg_valid && cfg_ready))
    else $error("command and config write accepted together");

  // At most one result commit per cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({dp_cmd.alloc_done, dp_cmd.free_done, dp_cmd.init_done, dp_cmd.resp_only}))
    else $error("more than one commit in a cycle");

  // A commit never overwrites a result that is still waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.alloc_done || dp_cmd.free_done || dp_cmd.init_done || dp_cmd.resp_only)
    |-> (!out_valid || out_ready))
    else $error("result overwritten while stalled");

  // One command in flight: ready drops right after an accept
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second command accepted while busy");

endmodule

### test/fixed_block_free_list_allocator_core_test.sv
`timescale 1ns / 1ps

module fixed_block_free_list_allocator_core_test;
  import fbfl_pkg::*;

  localparam int ARENA_BLOCKS = MAX_BLOCKS_DEF;
  localparam int WORD_B       = WORD_BYTES_DEF;
  localparam int IDLE_LIMIT   = 5000;
  localparam int LONG_HOLD    = 300;
  localparam int RAND_WORDS   = 62;

  typedef struct {
    cmd_t             cmd;
    logic [IDX_W-1:0] index;
    logic             is_null;
  } alloc_cmd_t;

  typedef struct {
    status_t          status;
    logic [IDX_W-1:0] index;
    logic [OFF_W-1:0] offset;
    logic [CNT_W-1:0] count;
  } alloc_resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CMD_W-1:0]  in_cmd = '0;
  logic [IDX_W-1:0]  in_free_index = '0;
  logic              in_free_is_null = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [ST_W-1:0]   out_status;
  logic [IDX_W-1:0]  out_block_index;
  logic [OFF_W-1:0]  out_block_offset;
  logic [CNT_W-1:0]  out_free_count;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  fixed_block_free_list_allocator_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_free_index   (in_free_index),
    .in_free_is_null (in_free_is_null),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_block_index (out_block_index),
    .out_block_offset(out_block_offset),
    .out_free_count  (out_free_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_addr        (cfg_addr),
    .cfg_data        (cfg_data)
  );

  // Shadow allocator state
  logic [CNT_W-1:0] link_mem [ARENA_BLOCKS];
  logic [CNT_W-1:0] head_ptr   = CNT_W'(ARENA_BLOCKS);
  logic [CNT_W-1:0] free_left  = '0;
  logic [CNT_W-1:0] cfg_blocks = BLOCKS_IN_USE_RST;
  logic [BB_W-1:0]  cfg_bytes  = BLOCK_BYTES_RST;

  alloc_cmd_t  cmd_q [$];
  alloc_resp_t pending_resp_q [$];
  alloc_cmd_t  cur_word;
  alloc_resp_t want;

  int unsigned n_pushed   = 0;
  int unsigned n_sent     = 0;
  int unsigned rx_count   = 0;
  int unsigned errors     = 0;
  int unsigned send_wait  = 0;
  int unsigned recv_wait  = 0;
  int unsigned hold_left  = 0;
  int unsigned idle_count = 0;
  bit          send_burst = 1'b0;
  bit          recv_burst = 1'b0;
  bit          long_done  = 1'b0;

  // Clock
  initial begin
    forever #2 clk = ~clk;
  end

  // Apply one command to the shadow list and return the result word it produces
  function automatic alloc_resp_t predict_word(input alloc_cmd_t c);
    alloc_resp_t r;
    int unsigned n;
    int unsigned sz;
    int unsigned blk;
    int unsigned i;
    r = '{ST_OK, '0, '0, '0};
    case (c.cmd)
      CMD_INIT: begin
        n = (cfg_blocks > ARENA_BLOCKS) ? ARENA_BLOCKS : cfg_blocks;
        if (n == 0) begin
          r.status = ST_INIT_FAIL;
        end else begin
          for (i = 0; i < n; i++) begin
            link_mem[i] = (i + 1 == n) ? CNT_W'(ARENA_BLOCKS) : CNT_W'(i + 1);
          end
          head_ptr  = '0;
          free_left = CNT_W'(n);
        end
      end
      CMD_ALLOC: begin
        if (head_ptr >= ARENA_BLOCKS) begin
          r.status = ST_EMPTY;
        end else begin
          blk      = head_ptr;
          head_ptr = link_mem[blk];
          if (free_left > 0) free_left = free_left - 1'b1;
          // size at least one word, rounded up to whole words
          sz       = (cfg_bytes < WORD_B) ? WORD_B : cfg_bytes;
          sz       = (sz + WORD_B - 1) / WORD_B * WORD_B;
          r.index  = IDX_W'(blk);
          r.offset = OFF_W'(WORD_B + blk * sz);
        end
      end
      CMD_FREE: begin
        if (!c.is_null) begin
          link_mem[c.index] = head_ptr;
          head_ptr = CNT_W'(c.index);
          if (free_left < ARENA_BLOCKS) free_left = free_left + 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.count = free_left;
    return r;
  endfunction

  // Per-word wait, with runs of back-to-back words
  function automatic int unsigned draw_wait(inout bit burst);
    if ($urandom_range(0, 19) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 17);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned exp_val);
    $display("mismatch at result %0d: %s got %0d, want %0d", rx_count, what, got, exp_val);
    errors++;
  endtask

  // Input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pending_resp_q.push_back(predict_word(cur_word));
        n_sent++;
      end
      if (in_valid && !in_ready) begin
        // hold the word until taken
      end else if (send_wait != 0) begin
        send_wait--;
        in_valid <= 1'b0;
      end else if (cmd_q.size() != 0) begin
        cur_word = cmd_q.pop_front();
        in_valid        <= 1'b1;
        in_cmd          <= cur_word.cmd;
        in_free_index   <= cur_word.index;
        in_free_is_null <= cur_word.is_null;
        send_wait = draw_wait(send_burst);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_resp_q.size() == 0) begin
          report_mismatch("unexpected result word, status", out_status, 0);
        end else begin
          want = pending_resp_q.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          if (out_block_index !== want.index)
            report_mismatch("block_index", out_block_index, want.index);
          if (out_block_offset !== want.offset)
            report_mismatch("block_offset", out_block_offset, want.offset);
          if (out_free_count !== want.count)
            report_mismatch("free_count", out_free_count, want.count);
        end
        rx_count++;
        recv_wait = draw_wait(recv_burst);
      end
      // one long hold-off while the sender still has plenty queued
      if (!long_done && rx_count >= 120 && cmd_q.size() > 20) begin
        hold_left = LONG_HOLD;
        long_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_wait != 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_count = 0;
      else
        idle_count++;
      if (idle_count >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic push_word(input cmd_t c, input int unsigned idx, input bit nul);
    alloc_cmd_t w;
    w = '{c, IDX_W'(idx), nul};
    cmd_q.push_back(w);
    n_pushed++;
  endtask

  // Wait until every queued word is taken and every result is back
  task automatic wait_idle();
    do @(posedge clk); while (n_sent != n_pushed || pending_resp_q.size() != 0);
  endtask

  task automatic write_reg(input cfg_reg_t r, input int unsigned v);
    cfg_valid <= 1'b1;
    cfg_addr  <= r;
    cfg_data  <= CFG_DW'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (r == CFG_BLOCKS_IN_USE) cfg_blocks = CNT_W'(v);
    else cfg_bytes = BB_W'(v);
  endtask

  task automatic set_geometry(input int unsigned blocks, input int unsigned bytes);
    wait_idle();
    write_reg(CFG_BLOCKS_IN_USE, blocks);
    @(posedge clk);
    write_reg(CFG_BLOCK_BYTES, bytes);
  endtask

  // Mostly allocate/free traffic on the linked blocks, some init, no-op and stray frees
  task automatic random_phase(input int unsigned blocks, input int unsigned bytes);
    int unsigned n;
    int unsigned k;
    int unsigned r;
    set_geometry(blocks, bytes);
    n = (blocks > ARENA_BLOCKS) ? ARENA_BLOCKS : blocks;
    push_word(CMD_INIT, $urandom_range(0, 255), 1'($urandom_range(0, 1)));
    for (k = 0; k < RAND_WORDS; k++) begin
      r = $urandom_range(0, 99);
      if (r < 4)
        push_word(CMD_INIT, $urandom_range(0, 255), 1'($urandom_range(0, 1)));
      else if (r < 9)
        push_word(CMD_NOP, $urandom_range(0, 255), 1'($urandom_range(0, 1)));
      else if (r < 52)
        push_word(CMD_ALLOC, $urandom_range(0, 255), 1'($urandom_range(0, 1)));
      else if (r < 57)
        push_word(CMD_FREE, $urandom_range(0, 255), 1'b1);
      else if (r < 90 && n != 0)
        push_word(CMD_FREE, $urandom_range(0, n - 1), 1'b0);
      else
        push_word(CMD_FREE, $urandom_range(0, 255), 1'b0);
    end
  endtask

  // Stimulus sequence
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset geometry: empty before init, null free, no-op, pops, double free
    push_word(CMD_ALLOC, 0, 1'b0);
    push_word(CMD_FREE, 5, 1'b1);
    push_word(CMD_NOP, 255, 1'b1);
    push_word(CMD_INIT, 0, 1'b0);
    push_word(CMD_ALLOC, 0, 1'b0);
    push_word(CMD_ALLOC, 0, 1'b0);
    push_word(CMD_FREE, 255, 1'b0);
    push_word(CMD_ALLOC, 0, 1'b0);
    push_word(CMD_FREE, 0, 1'b0);
    push_word(CMD_FREE, 0, 1'b0);
    push_word(CMD_FREE, 1, 1'b0);
    push_word(CMD_ALLOC, 0, 1'b0);

    // zero count: init fails, old list stays; one-byte blocks round to a word
    set_geometry(0, 1);
    push_word(CMD_INIT, 0, 1'b0);
    push_word(CMD_ALLOC, 0, 1'b0);

    // single block list
    set_geometry(1, 0);
    push_word(CMD_INIT, 0, 1'b0);
    push_word(CMD_ALLOC, 0, 1'b0);
    push_word(CMD_ALLOC, 0, 1'b0);
    push_word(CMD_FREE, 0, 1'b0);
    push_word(CMD_ALLOC, 0, 1'b0);

    // count clamped to the arena, largest size wraps the offset
    set_geometry(511, 8191);
    push_word(CMD_INIT, 0, 1'b0);
    push_word(CMD_FREE, 255, 1'b0);
    push_word(CMD_ALLOC, 0, 1'b0);

    // self-linked block after double free: count runs down to zero and holds
    set_geometry(2, 9);
    push_word(CMD_INIT, 0, 1'b0);
    push_word(CMD_FREE, 0, 1'b0);
    repeat (4) push_word(CMD_ALLOC, 0, 1'b0);

    // random traffic over several geometries
    random_phase(256, 8);
    random_phase(3, 24);
    random_phase(511, 8191);
    random_phase(2, 4096);
    random_phase(1, 0);
    random_phase(0, 100);
    random_phase($urandom_range(1, 300), $urandom_range(0, 8191));
    random_phase($urandom_range(4, 40), $urandom_range(0, 8191));

    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_resp_q.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
